// ===== rtl/lav_pkg.sv =====
// Shared types, constants and saturation helper for the look-at view matrix block.
// No dependencies; imported by lav_norm and look_at_view_matrix.
package lav_pkg;

  localparam int WORD_W   = 32;
  localparam int NORM_W   = 30;
  localparam int NORM_MSB = 29;
  localparam int ROOT_W   = 31;
  localparam int SQ_W     = 62;

  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [WORD_W-1:0] side_x;
    logic [WORD_W-1:0] side_y;
    logic [WORD_W-1:0] side_z;
    logic [WORD_W-1:0] side_offset;
    logic [WORD_W-1:0] upward_x;
    logic [WORD_W-1:0] upward_y;
    logic [WORD_W-1:0] upward_z;
    logic [WORD_W-1:0] upward_offset;
    logic [WORD_W-1:0] back_x;
    logic [WORD_W-1:0] back_y;
    logic [WORD_W-1:0] back_z;
    logic [WORD_W-1:0] forward_offset;
  } res_t;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [63:0] x);
    logic [WORD_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[WORD_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[WORD_W-1:0];
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/lav_norm.sv =====
// Pipelined 3-vector normalizer: block scaling, sum of squares, bit-serial square
// root and restoring division, one step per stage. Uses lav_pkg.
module lav_norm #(
  parameter int IN_W   = 33,
  parameter int FRAC   = 16,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][IN_W-1:0]        in_vec,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [2:0][FRAC+1:0]        out_vec,
  output logic [SIDE_W-1:0]           out_side
);
  import lav_pkg::*;

  localparam int POS_W     = $clog2(IN_W);
  localparam int QW        = FRAC + 1;
  localparam int OUT_W     = FRAC + 2;
  localparam int NUM_W     = NORM_W + FRAC + 1;
  localparam int DIV_STEPS = FRAC + 1;

  typedef struct packed {
    logic [SIDE_W-1:0]            side;
    logic                         zero;
    logic [2:0]                   neg;
    logic [2:0][NORM_W-1:0]       m;
  } hold_t;

  typedef struct packed {
    logic [SIDE_W-1:0]            side;
    logic                         zero;
    logic [2:0]                   neg;
    logic [ROOT_W-1:0]            len;
  } quo_t;

  logic                          a_v;
  logic [2:0]                    a_neg;
  logic [2:0][IN_W-1:0]          a_mag;
  logic [SIDE_W-1:0]             a_side;

  logic                          b_v;
  logic [2:0]                    b_neg;
  logic [2:0][IN_W-1:0]          b_mag;
  logic [POS_W-1:0]              b_pos;
  logic                          b_zero;
  logic [SIDE_W-1:0]             b_side;
  logic [IN_W-1:0]               or_all;
  logic [POS_W-1:0]              pos_next;

  logic                          c_v;
  hold_t                         c_h;
  logic [2:0][NORM_W-1:0]        m_next;
  logic [2:0][IN_W-1:0]          rsh;
  logic [2:0][NORM_W-1:0]        lsh;

  logic                          d_v;
  hold_t                         d_h;
  logic [2:0][2*NORM_W-1:0]      d_sq;

  logic                          r_v [0:ROOT_W];
  logic [SQ_W-1:0]               r_n [0:ROOT_W];
  logic [SQ_W-1:0]               r_r [0:ROOT_W];
  hold_t                         r_h [0:ROOT_W];

  logic                          q_v   [0:DIV_STEPS];
  logic [2:0][NUM_W-1:0]         q_rem [0:DIV_STEPS];
  logic [2:0][QW-1:0]            q_q   [0:DIV_STEPS];
  quo_t                          q_c   [0:DIV_STEPS];

  logic [2:0][OUT_W-1:0]         o_next;
  logic [2:0][OUT_W-1:0]         o_mag;
  logic [ROOT_W-1:0]             root;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) r_v[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) q_v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      r_v[0] <= d_v;
      for (int k = 0; k < ROOT_W; k++) r_v[k+1] <= r_v[k];
      q_v[0] <= r_v[ROOT_W];
      for (int k = 0; k < DIV_STEPS; k++) q_v[k+1] <= q_v[k];
      out_valid <= q_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][IN_W-1];
        a_mag[i] <= in_vec[i][IN_W-1] ? -in_vec[i] : in_vec[i];
      end
      a_side <= in_side;
    end
  end

  always_comb begin
    or_all   = a_mag[0] | a_mag[1] | a_mag[2];
    pos_next = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (or_all[k]) pos_next = POS_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_neg  <= a_neg;
      b_mag  <= a_mag;
      b_pos  <= pos_next;
      b_zero <= (or_all == '0);
      b_side <= a_side;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i] = b_mag[i] >> (b_pos - POS_W'(NORM_MSB));
      lsh[i] = NORM_W'(b_mag[i]) << (POS_W'(NORM_MSB) - b_pos);
      m_next[i] = (b_pos >= POS_W'(NORM_MSB)) ? rsh[i][NORM_W-1:0] : lsh[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_h.side <= b_side;
      c_h.zero <= b_zero;
      c_h.neg  <= b_neg;
      c_h.m    <= m_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_sq[i] <= c_h.m[i] * c_h.m[i];
      d_h <= c_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_n[0] <= SQ_W'(d_sq[0]) + SQ_W'(d_sq[1]) + SQ_W'(d_sq[2]);
      r_r[0] <= '0;
      r_h[0] <= d_h;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = r_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (r_n[k] >= trial) begin
          r_n[k+1] <= r_n[k] - trial;
          r_r[k+1] <= (r_r[k] >> 1) + BIT;
        end else begin
          r_n[k+1] <= r_n[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
        r_h[k+1] <= r_h[k];
      end
    end
  end

  assign root = r_r[ROOT_W][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_rem[0][i] <= (NUM_W'(r_h[ROOT_W].m[i]) << FRAC) + NUM_W'(root >> 1);
      end
      q_q[0]      <= '0;
      q_c[0].side <= r_h[ROOT_W].side;
      q_c[0].zero <= r_h[ROOT_W].zero;
      q_c[0].neg  <= r_h[ROOT_W].neg;
      q_c[0].len  <= root;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = FRAC - j;
    logic [NUM_W-1:0] dvs;
    assign dvs = NUM_W'(q_c[j].len) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (q_rem[j][i] >= dvs) begin
            q_rem[j+1][i] <= q_rem[j][i] - dvs;
            q_q[j+1][i]   <= q_q[j][i] | (QW'(1) << SH);
          end else begin
            q_rem[j+1][i] <= q_rem[j][i];
            q_q[j+1][i]   <= q_q[j][i];
          end
        end
        q_c[j+1] <= q_c[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_mag[i] = {1'b0, q_q[DIV_STEPS][i]};
      if (q_c[DIV_STEPS].zero) begin
        o_next[i] = '0;
      end else if (q_c[DIV_STEPS].neg[i]) begin
        o_next[i] = -o_mag[i];
      end else begin
        o_next[i] = o_mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec  <= o_next;
      out_side <= q_c[DIV_STEPS].side;
    end
  end

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Top level of the look-at view matrix pipeline: cross and dot products around two
// lav_norm normalizers, plus a two-entry output skid buffer. Uses lav_pkg.
//
// Usage: present eye, target and up (signed fixed point, FRAC_BITS fraction bits)
// with in_valid; a transaction is taken when in_valid and in_ready are high.
// One result transaction of twelve matrix entries leaves on out_valid/out_ready.
// Throughput: one transaction per cycle, sustained, while the receiver keeps up.
// Each normalizer spends 31 stages on its square root, one result bit per stage,
// and FRAC_BITS + 1 stages on its divisions.
// The whole pipeline advances together; it holds only when both skid entries
// are occupied, so results keep flowing into the skid buffer while the receiver
// stalls, and in_ready drops once the buffer is full.
// Reset clears all valid bits and the skid buffer; no result is pending after it.
// Zero forward: all outputs zero; zero side: side/upward rows and offsets zero.
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          eye_x,
  input  logic signed [31:0]          eye_y,
  input  logic signed [31:0]          eye_z,
  input  logic signed [31:0]          target_x,
  input  logic signed [31:0]          target_y,
  input  logic signed [31:0]          target_z,
  input  logic signed [31:0]          up_x,
  input  logic signed [31:0]          up_y,
  input  logic signed [31:0]          up_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          side_x,
  output logic signed [31:0]          side_y,
  output logic signed [31:0]          side_z,
  output logic signed [31:0]          side_offset,
  output logic signed [31:0]          upward_x,
  output logic signed [31:0]          upward_y,
  output logic signed [31:0]          upward_z,
  output logic signed [31:0]          upward_offset,
  output logic signed [31:0]          back_x,
  output logic signed [31:0]          back_y,
  output logic signed [31:0]          back_z,
  output logic signed [31:0]          forward_offset
);
  import lav_pkg::*;

  localparam int D_W   = WORD_W + 1;
  localparam int F_W   = FRAC_BITS + 2;
  localparam int P_W   = WORD_W + F_W;
  localparam int C_W   = P_W + 1;
  localparam int U_P   = 2 * F_W;
  localparam int UD_W  = U_P + 1;
  localparam int U_W   = FRAC_BITS + 3;
  localparam int E_P   = WORD_W + F_W;
  localparam int DS_W  = E_P + 2;
  localparam int EU_P  = WORD_W + U_W;
  localparam int DU_W  = EU_P + 2;

  localparam logic signed [UD_W-1:0] HALF_U = UD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DS_W-1:0] HALF_D = DS_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DU_W-1:0] HALF_E = DU_W'(1) << (FRAC_BITS - 1);
  localparam logic [1:0]             SKID_DEPTH = 2'd2;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] eye;
    logic [2:0][WORD_W-1:0] up;
  } side1_t;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] eye;
    logic [2:0][F_W-1:0]    f;
  } side2_t;

  logic                      en;

  logic                      t0_v;
  logic [2:0][D_W-1:0]       t0_d;
  side1_t                    t0_s;

  logic                      n1_v;
  logic [2:0][F_W-1:0]       n1_f;
  side1_t                    n1_s;

  logic                      x1_v;
  logic signed [P_W-1:0]     x1_p [6];
  side2_t                    x1_s;

  logic                      x2_v;
  logic [2:0][C_W-1:0]       x2_c;
  side2_t                    x2_s;

  logic                      n2_v;
  logic [2:0][F_W-1:0]       n2_sv;
  side2_t                    n2_s;

  logic                      y1_v;
  logic signed [U_P-1:0]     y1_pu [6];
  logic signed [E_P-1:0]     y1_ps [3];
  logic signed [E_P-1:0]     y1_pf [3];
  logic [2:0][F_W-1:0]       y1_sv;
  side2_t                    y1_s;

  logic                      y2_v;
  logic signed [U_W-1:0]     y2_u [3];
  logic signed [DS_W-1:0]    y2_ds;
  logic signed [DS_W-1:0]    y2_df;
  logic [2:0][F_W-1:0]       y2_sv;
  side2_t                    y2_s;

  logic signed [UD_W-1:0]    ud [3];
  logic signed [UD_W-1:0]    ur [3];
  logic signed [DS_W-1:0]    ssum;
  logic signed [DS_W-1:0]    fsum;
  logic signed [DS_W-1:0]    sr;
  logic signed [DS_W-1:0]    fr;

  logic                      y3_v;
  logic signed [EU_P-1:0]    y3_pe [3];
  logic signed [U_W-1:0]     y3_u [3];
  logic signed [DS_W-1:0]    y3_ds;
  logic signed [DS_W-1:0]    y3_df;
  logic [2:0][F_W-1:0]       y3_sv;
  side2_t                    y3_s;

  logic signed [DU_W-1:0]    usum;
  logic signed [DU_W-1:0]    urnd;
  logic signed [63:0]        ds64;
  logic signed [63:0]        df64;
  logic signed [63:0]        du64;
  logic signed [F_W-1:0]     nb [3];
  res_t                      res_next;

  logic                      y4_v;
  res_t                      y4_res;

  logic [1:0]                cnt;
  logic                      wp;
  logic                      rp;
  logic                      push;
  logic                      pop;
  res_t                      skid_mem [2];

  assign en       = (cnt != SKID_DEPTH);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      y1_v <= 1'b0;
      y2_v <= 1'b0;
      y3_v <= 1'b0;
      y4_v <= 1'b0;
    end else if (en) begin
      t0_v <= in_valid;
      x1_v <= n1_v;
      x2_v <= x1_v;
      y1_v <= n2_v;
      y2_v <= y1_v;
      y3_v <= y2_v;
      y4_v <= y3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= {target_x[31], target_x} - {eye_x[31], eye_x};
      t0_d[1] <= {target_y[31], target_y} - {eye_y[31], eye_y};
      t0_d[2] <= {target_z[31], target_z} - {eye_z[31], eye_z};
      t0_s.eye <= {eye_z, eye_y, eye_x};
      t0_s.up  <= {up_z, up_y, up_x};
    end
  end

  lav_norm #(
    .IN_W   (D_W),
    .FRAC   (FRAC_BITS),
    .SIDE_W ($bits(side1_t))
  ) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t0_v),
    .in_vec    (t0_d),
    .in_side   (t0_s),
    .out_valid (n1_v),
    .out_vec   (n1_f),
    .out_side  (n1_s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x1_p[0] <= $signed(n1_s.up[1]) * $signed(n1_f[2]);
      x1_p[1] <= $signed(n1_s.up[2]) * $signed(n1_f[1]);
      x1_p[2] <= $signed(n1_s.up[2]) * $signed(n1_f[0]);
      x1_p[3] <= $signed(n1_s.up[0]) * $signed(n1_f[2]);
      x1_p[4] <= $signed(n1_s.up[0]) * $signed(n1_f[1]);
      x1_p[5] <= $signed(n1_s.up[1]) * $signed(n1_f[0]);
      x1_s.eye <= n1_s.eye;
      x1_s.f   <= n1_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        x2_c[i] <= {x1_p[2*i][P_W-1], x1_p[2*i]} - {x1_p[2*i+1][P_W-1], x1_p[2*i+1]};
      end
      x2_s <= x1_s;
    end
  end

  lav_norm #(
    .IN_W   (C_W),
    .FRAC   (FRAC_BITS),
    .SIDE_W ($bits(side2_t))
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x2_v),
    .in_vec    (x2_c),
    .in_side   (x2_s),
    .out_valid (n2_v),
    .out_vec   (n2_sv),
    .out_side  (n2_s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      y1_pu[0] <= $signed(n2_s.f[1]) * $signed(n2_sv[2]);
      y1_pu[1] <= $signed(n2_s.f[2]) * $signed(n2_sv[1]);
      y1_pu[2] <= $signed(n2_s.f[2]) * $signed(n2_sv[0]);
      y1_pu[3] <= $signed(n2_s.f[0]) * $signed(n2_sv[2]);
      y1_pu[4] <= $signed(n2_s.f[0]) * $signed(n2_sv[1]);
      y1_pu[5] <= $signed(n2_s.f[1]) * $signed(n2_sv[0]);
      for (int i = 0; i < 3; i++) begin
        y1_ps[i] <= $signed(n2_sv[i]) * $signed(n2_s.eye[i]);
        y1_pf[i] <= $signed(n2_s.f[i]) * $signed(n2_s.eye[i]);
      end
      y1_sv <= n2_sv;
      y1_s  <= n2_s;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ud[i] = UD_W'(y1_pu[2*i]) - UD_W'(y1_pu[2*i+1]);
      ur[i] = (ud[i] + HALF_U) >>> FRAC_BITS;
    end
    ssum = DS_W'(y1_ps[0]) + DS_W'(y1_ps[1]) + DS_W'(y1_ps[2]);
    fsum = DS_W'(y1_pf[0]) + DS_W'(y1_pf[1]) + DS_W'(y1_pf[2]);
    sr   = (ssum + HALF_D) >>> FRAC_BITS;
    fr   = (fsum + HALF_D) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) y2_u[i] <= ur[i][U_W-1:0];
      y2_ds <= sr;
      y2_df <= fr;
      y2_sv <= y1_sv;
      y2_s  <= y1_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y3_pe[i] <= y2_u[i] * $signed(y2_s.eye[i]);
      end
      y3_u  <= y2_u;
      y3_ds <= y2_ds;
      y3_df <= y2_df;
      y3_sv <= y2_sv;
      y3_s  <= y2_s;
    end
  end

  always_comb begin
    usum = DU_W'(y3_pe[0]) + DU_W'(y3_pe[1]) + DU_W'(y3_pe[2]);
    urnd = (usum + HALF_E) >>> FRAC_BITS;
    ds64 = {{(64-DS_W){y3_ds[DS_W-1]}}, y3_ds};
    df64 = {{(64-DS_W){y3_df[DS_W-1]}}, y3_df};
    du64 = {{(64-DU_W){urnd[DU_W-1]}}, urnd};
    for (int i = 0; i < 3; i++) nb[i] = -$signed(y3_s.f[i]);
    res_next.side_x         = {{(WORD_W-F_W){y3_sv[0][F_W-1]}}, y3_sv[0]};
    res_next.side_y         = {{(WORD_W-F_W){y3_sv[1][F_W-1]}}, y3_sv[1]};
    res_next.side_z         = {{(WORD_W-F_W){y3_sv[2][F_W-1]}}, y3_sv[2]};
    res_next.side_offset    = sat_word(-ds64);
    res_next.upward_x       = {{(WORD_W-U_W){y3_u[0][U_W-1]}}, y3_u[0]};
    res_next.upward_y       = {{(WORD_W-U_W){y3_u[1][U_W-1]}}, y3_u[1]};
    res_next.upward_z       = {{(WORD_W-U_W){y3_u[2][U_W-1]}}, y3_u[2]};
    res_next.upward_offset  = sat_word(-du64);
    res_next.back_x         = {{(WORD_W-F_W){nb[0][F_W-1]}}, nb[0]};
    res_next.back_y         = {{(WORD_W-F_W){nb[1][F_W-1]}}, nb[1]};
    res_next.back_z         = {{(WORD_W-F_W){nb[2][F_W-1]}}, nb[2]};
    res_next.forward_offset = sat_word(df64);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y4_res <= res_next;
    end
  end

  assign push = en & y4_v;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      skid_mem[wp] <= y4_res;
    end
  end

  assign out_valid      = (cnt != 2'd0);
  assign side_x         = skid_mem[rp].side_x;
  assign side_y         = skid_mem[rp].side_y;
  assign side_z         = skid_mem[rp].side_z;
  assign side_offset    = skid_mem[rp].side_offset;
  assign upward_x       = skid_mem[rp].upward_x;
  assign upward_y       = skid_mem[rp].upward_y;
  assign upward_z       = skid_mem[rp].upward_z;
  assign upward_offset  = skid_mem[rp].upward_offset;
  assign back_x         = skid_mem[rp].back_x;
  assign back_y         = skid_mem[rp].back_y;
  assign back_z         = skid_mem[rp].back_z;
  assign forward_offset = skid_mem[rp].forward_offset;

  a_skid_bound: assert property (@(posedge clk) disable iff (rst) cnt <= SKID_DEPTH)
    else $error("skid buffer count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(t0_v) && $stable(y4_v) && $stable(y3_v))
    else $error("pipeline moved while held");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> out_valid)
    else $error("pushed result not visible");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid && cnt == 2'd0)
    else $error("result pending after reset");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for look_at_view_matrix: a driver queue feeds camera
// transactions, a predictor computes the view matrix, a monitor compares results.
// Depends on lav_pkg and the look_at_view_matrix RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lav_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 2 * FB + 86;
  localparam int CYCLE_LIMIT = 400000;
  localparam string FIELD_NAMES [12] = '{"side_x", "side_y", "side_z", "side_offset",
    "upward_x", "upward_y", "upward_z", "upward_offset", "back_x", "back_y", "back_z",
    "forward_offset"};

  typedef struct {
    logic signed [31:0] v [9];
  } camera_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] side_x, side_y, side_z, side_offset;
  logic signed [31:0] upward_x, upward_y, upward_z, upward_offset;
  logic signed [31:0] back_x, back_y, back_z, forward_offset;

  look_at_view_matrix #(.FRAC_BITS(FB)) DUT (.*);

  camera_t pending_cams [$];
  res_t expected_matrices [$];
  int mismatches = 0;
  int accepted = 0;
  int received = 0;
  int cycles = 0;
  int hold_off_cycles = 0;
  bit send_pause = 1'b0;
  bit no_idle = 1'b0;
  bit stimulus_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint shift_floor(longint x, int sh);
    return x >>> sh;
  endfunction

  function automatic longint round_q(longint x);
    return shift_floor(x + (longint'(1) << (FB - 1)), FB);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Exact for inputs below 2^64 in magnitude; cross terms fit 64 bits here.
  function automatic void unit_vector(input longint v [3], output longint r [3]);
    longint unsigned m [3];
    longint unsigned mx, sq, len, q;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      r = '{0, 0, 0};
      return;
    end
    while ((mx >> 30) != 0) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (longint'(1) << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic res_t view_matrix(camera_t c);
    longint e [3], t [3], u [3], d [3], f [3], x [3], s [3], w [3];
    res_t r;
    for (int i = 0; i < 3; i++) begin
      e[i] = c.v[i];
      t[i] = c.v[3 + i];
      u[i] = c.v[6 + i];
      d[i] = t[i] - e[i];
    end
    unit_vector(d, f);
    x[0] = u[1] * f[2] - u[2] * f[1];
    x[1] = u[2] * f[0] - u[0] * f[2];
    x[2] = u[0] * f[1] - u[1] * f[0];
    unit_vector(x, s);
    w[0] = round_q(f[1] * s[2] - f[2] * s[1]);
    w[1] = round_q(f[2] * s[0] - f[0] * s[2]);
    w[2] = round_q(f[0] * s[1] - f[1] * s[0]);
    r.side_x = 32'(s[0]);
    r.side_y = 32'(s[1]);
    r.side_z = 32'(s[2]);
    r.side_offset = 32'(clamp32(-round_q(s[0] * e[0] + s[1] * e[1] + s[2] * e[2])));
    r.upward_x = 32'(w[0]);
    r.upward_y = 32'(w[1]);
    r.upward_z = 32'(w[2]);
    r.upward_offset = 32'(clamp32(-round_q(w[0] * e[0] + w[1] * e[1] + w[2] * e[2])));
    r.back_x = 32'(-f[0]);
    r.back_y = 32'(-f[1]);
    r.back_z = 32'(-f[2]);
    r.forward_offset = 32'(clamp32(round_q(f[0] * e[0] + f[1] * e[1] + f[2] * e[2])));
    return r;
  endfunction

  function automatic logic [31:0] pick_word(int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic camera_t random_camera();
    camera_t c;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      c.v[i] = pick_word(mode < 5 ? 2 : (mode < 7 ? 4 : $urandom_range(0, 4)));
    end
    case ($urandom_range(0, 11))
      0: for (int i = 0; i < 3; i++) c.v[3 + i] = c.v[i];
      1: for (int i = 0; i < 3; i++) c.v[6 + i] = c.v[3 + i] - c.v[i];
      2: for (int i = 0; i < 3; i++) c.v[6 + i] = 0;
      3: c.v[$urandom_range(0, 8)] = pick_word($urandom_range(0, 1));
      default: ;
    endcase
    return c;
  endfunction

  function automatic camera_t make_camera(int e0, int e1, int e2, int t0, int t1, int t2,
                                          int u0, int u1, int u2);
    camera_t c;
    c.v = '{e0, e1, e2, t0, t1, t2, u0, u1, u2};
    return c;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_matrices.push_back(view_matrix(pending_cams.pop_front()));
        accepted++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_cams.size() > 0 && !send_pause
                   && (no_idle || $urandom_range(0, 99) >= 27)) begin
        {eye_x, eye_y, eye_z} <= {pending_cams[0].v[0], pending_cams[0].v[1],
          pending_cams[0].v[2]};
        {target_x, target_y, target_z} <= {pending_cams[0].v[3], pending_cams[0].v[4],
          pending_cams[0].v[5]};
        {up_x, up_y, up_z} <= {pending_cams[0].v[6], pending_cams[0].v[7],
          pending_cams[0].v[8]};
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{side_x, side_y, side_z, side_offset, upward_x, upward_y, upward_z,
                upward_offset, back_x, back_y, back_z, forward_offset};
        received++;
        if (expected_matrices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction %0d", received);
        end else begin
          want = expected_matrices.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (got[383 - 32 * i -: 32] !== want[383 - 32 * i -: 32]) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("Result %0d %s: expected %0d got %0d", received, FIELD_NAMES[i],
                         $signed(want[383 - 32 * i -: 32]), $signed(got[383 - 32 * i -: 32]));
              end
            end
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(0, 99) >= 27;
      end
    end
  end

  initial begin
    int edge_vals [4];
    edge_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    pending_cams.push_back(make_camera(0, 0, 0, 0, 0, -65536, 0, 65536, 0));
    pending_cams.push_back(make_camera(65536, 2 << 16, 3 << 16, 65536, 2 << 16, 3 << 16,
                                       0, 65536, 0));
    pending_cams.push_back(make_camera(0, 0, 0, 0, 0, 65536, 0, 0, 3 << 16));
    pending_cams.push_back(make_camera(0, 0, 0, 65536, 0, 0, 0, 0, 0));
    pending_cams.push_back(make_camera(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 65536, 0, 0));
    pending_cams.push_back(make_camera(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    pending_cams.push_back(make_camera(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 1, 0,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
    pending_cams.push_back(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_cams.push_back(make_camera(1, -1, 1, 1, -1, 2, -1, -1, -1));
    for (int k = 0; k < 12; k++) begin
      camera_t c;
      for (int i = 0; i < 9; i++) c.v[i] = edge_vals[$urandom_range(0, 3)];
      pending_cams.push_back(c);
    end
    wait (pending_cams.size() == 0);
    for (int k = 0; k < 1400; k++) begin
      if (k == 300) begin
        wait (pending_cams.size() == 0);
        hold_off_cycles = 400;
      end
      if (k == 600) begin
        wait (pending_cams.size() == 0);
        send_pause = 1'b1;
        wait (expected_matrices.size() == 0 && !in_valid);
        send_pause = 1'b0;
      end
      if (k == 800) no_idle = 1'b1;
      if (k == 1100) no_idle = 1'b0;
      pending_cams.push_back(random_camera());
      if (pending_cams.size() > 200) wait (pending_cams.size() < 100);
    end
    wait (pending_cams.size() == 0 && !in_valid);
    wait (expected_matrices.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d cameras, checked %0d view matrices including degenerate cases",
             accepted, received);
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, expected_matrices.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix.sv
tb/testbench.sv
